### rtl/kscc_pkg.sv
// Shared types for the kill-switch channel controller.
// Channel state encoding, per-channel control and LED flag bundles.
// No dependencies.
package kscc_pkg;

  localparam int unsigned MAX_CHANNELS  = 4;
  localparam logic [3:0]  SWITCH_MASK   = 4'h0F;
  localparam logic [15:0] DEBOUNCE_INIT = 16'd25;

  typedef enum logic [1:0] {
    CH_IDLE   = 2'd0,
    CH_FLIGHT = 2'd1,
    CH_DONE   = 2'd2
  } chan_state_t;

  typedef struct packed {
    logic armed;
    logic held;
    logic ack;
    logic fail;
    logic accept;
  } chan_ctl_t;

  typedef struct packed {
    logic fault;
    logic rx;
    logic killed;
  } chan_flags_t;

endpackage

### rtl/kscc_channel.sv
// Per-channel poll logic: acknowledge, fail and switch handling for one channel.
// Purely combinational; depends on kscc_pkg.
module kscc_channel (
  input  kscc_pkg::chan_state_t state,
  input  kscc_pkg::chan_flags_t flags,
  input  kscc_pkg::chan_ctl_t   ctl,
  output kscc_pkg::chan_state_t state_next,
  output kscc_pkg::chan_flags_t flags_next,
  output logic                  sent
);
  import kscc_pkg::*;

  always_comb begin
    state_next = state;
    flags_next = flags;
    sent       = 1'b0;

    if (ctl.ack) begin
      flags_next.rx = 1'b1;
      state_next    = CH_DONE;
    end

    if (ctl.fail) begin
      flags_next.fault = 1'b1;
      if (ctl.held && ctl.accept) begin
        state_next = CH_FLIGHT;
        sent       = 1'b1;
      end else begin
        state_next = CH_IDLE;
      end
    end

    if (ctl.armed) begin
      if (!ctl.held) begin
        state_next = CH_IDLE;
        flags_next = '0;
      end else if (state_next == CH_IDLE) begin
        flags_next.killed = 1'b1;
        if (ctl.accept) begin
          state_next = CH_FLIGHT;
          sent       = 1'b1;
        end else begin
          flags_next.fault = 1'b1;
        end
      end
    end
  end

endmodule

### rtl/kill_switch_channel_controller_unit.sv
// Top level of the kill-switch channel controller: input register, switch
// debounce, per-channel logic and result register. Depends on kscc_pkg, kscc_channel.
//
//   channel | handshake           | word
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_stall | armed switch_port read_valid now_ms ack/fail/accept
//   out     | out_valid/out_stall | send_mask led_port_a led_port_b arm_led states
//   cfg     | cfg_we              | cfg_wdata (debounce period)
//
// One word per cycle sustained while out_stall is low; each result is registered.
// Channel state and latches update when a word moves from the input register to the
// result register, so the next word sees them with no gap.
// rst (synchronous) clears all state and loads the debounce period with 25.
// A stalled result holds; the input register still takes a word while it is empty.
module kill_switch_channel_controller_unit #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        armed,
  input  logic [7:0]  switch_port,
  input  logic        read_valid,
  input  logic [31:0] now_ms,
  input  logic [3:0]  ack_events,
  input  logic [3:0]  fail_events,
  input  logic [3:0]  send_accept,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  send_mask,
  output logic [7:0]  led_port_a,
  output logic [7:0]  led_port_b,
  output logic        arm_led,
  output logic [7:0]  channel_states
);
  import kscc_pkg::*;

  logic [15:0] debounce_val;

  logic        s1_valid;
  logic        s1_armed;
  logic [7:0]  s1_port;
  logic        s1_read_valid;
  logic [31:0] s1_now;
  logic [3:0]  s1_ack;
  logic [3:0]  s1_fail;
  logic [3:0]  s1_accept;

  chan_state_t chan_state      [CHANNELS];
  chan_state_t chan_state_next [CHANNELS];
  logic [7:0]  fault_rx_latch;
  logic [7:0]  fault_rx_next;
  logic [3:0]  killed_latch;
  logic [3:0]  killed_next;
  logic [3:0]  raw_switches;
  logic [3:0]  raw_switches_next;
  logic [3:0]  stable_switches;
  logic [3:0]  stable_switches_next;
  logic [31:0] raw_since_ms;
  logic [31:0] raw_since_ms_next;

  logic [3:0]  raw_now;
  logic [31:0] elapsed;
  logic [3:0]  sent_vec;
  logic [7:0]  states_vec;
  logic [3:0]  flight_mask;
  logic        advance;
  logic        in_take;

  // Handshake: the result register frees when it is empty or taken.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_val <= DEBOUNCE_INIT;
    end else if (cfg_we) begin
      debounce_val <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_armed      <= armed;
      s1_port       <= switch_port;
      s1_read_valid <= read_valid;
      s1_now        <= now_ms;
      s1_ack        <= ack_events;
      s1_fail       <= fail_events;
      s1_accept     <= send_accept;
    end
  end

  // Debounce the active-low switches as a group.
  assign raw_now = ~s1_port[3:0] & SWITCH_MASK;
  assign elapsed = s1_now - raw_since_ms;

  always_comb begin
    raw_switches_next    = raw_switches;
    raw_since_ms_next    = raw_since_ms;
    stable_switches_next = stable_switches;
    if (s1_read_valid) begin
      if (raw_now != raw_switches) begin
        raw_switches_next = raw_now;
        raw_since_ms_next = s1_now;
      end else if (elapsed >= {16'd0, debounce_val}) begin
        stable_switches_next = raw_now;
      end
    end
  end

  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_chan
    if (ch < CHANNELS) begin : g_on
      chan_ctl_t   ctl;
      chan_flags_t flags;
      chan_flags_t flags_next;

      assign ctl.armed  = s1_armed;
      assign ctl.held   = stable_switches_next[ch];
      assign ctl.ack    = s1_ack[ch];
      assign ctl.fail   = s1_fail[ch];
      assign ctl.accept = s1_accept[ch];

      assign flags.fault  = fault_rx_latch[ch];
      assign flags.rx     = fault_rx_latch[4+ch];
      assign flags.killed = killed_latch[ch];

      kscc_channel u_chan (
        .state      (chan_state[ch]),
        .flags      (flags),
        .ctl        (ctl),
        .state_next (chan_state_next[ch]),
        .flags_next (flags_next),
        .sent       (sent_vec[ch])
      );

      assign fault_rx_next[ch]   = flags_next.fault;
      assign fault_rx_next[4+ch] = flags_next.rx;
      assign killed_next[ch]     = flags_next.killed;
      assign states_vec[2*ch +: 2] = chan_state_next[ch];
      assign flight_mask[ch]       = (channel_states[2*ch +: 2] == CH_FLIGHT);
    end else begin : g_off
      assign fault_rx_next[ch]     = fault_rx_latch[ch];
      assign fault_rx_next[4+ch]   = fault_rx_latch[4+ch];
      assign killed_next[ch]       = killed_latch[ch];
      assign sent_vec[ch]          = 1'b0;
      assign states_vec[2*ch +: 2] = 2'd0;
      assign flight_mask[ch]       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int unsigned k = 0; k < CHANNELS; k++) begin
        chan_state[k] <= CH_IDLE;
      end
      fault_rx_latch  <= '0;
      killed_latch    <= '0;
      raw_switches    <= '0;
      stable_switches <= '0;
      raw_since_ms    <= '0;
    end else if (advance) begin
      for (int unsigned k = 0; k < CHANNELS; k++) begin
        chan_state[k] <= chan_state_next[k];
      end
      fault_rx_latch  <= fault_rx_next;
      killed_latch    <= killed_next;
      raw_switches    <= raw_switches_next;
      stable_switches <= stable_switches_next;
      raw_since_ms    <= raw_since_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      send_mask      <= sent_vec;
      led_port_a     <= fault_rx_next;
      led_port_b     <= {killed_next, 4'b0000};
      arm_led        <= s1_armed;
      channel_states <= states_vec;
    end
  end

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_sent_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((send_mask & ~flight_mask) == 4'd0))
    else $error("send reported on a channel not in flight");

  a_stable_from_raw: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(stable_switches)) |-> (stable_switches == raw_switches))
    else $error("stable switches moved away from the raw value");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> !$past(advance))
    else $error("result register overwritten while stalled");

endmodule

### test/tb_kill_switch_channel_controller_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for kill_switch_channel_controller_unit: a local predictor of
// switch debounce, channel machines and LED latches checks every result word.
// Depends on kscc_pkg and the RTL of the block only.
module tb_kill_switch_channel_controller_unit;
  import kscc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic        armed;
    logic [7:0]  switch_port;
    logic        read_valid;
    logic [31:0] now_ms;
    logic [3:0]  ack_events;
    logic [3:0]  fail_events;
    logic [3:0]  send_accept;
  } poll_word_t;

  typedef struct packed {
    logic [3:0] send_mask;
    logic [7:0] led_port_a;
    logic [7:0] led_port_b;
    logic       arm_led;
    logic [7:0] channel_states;
  } poll_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        armed;
  logic [7:0]  switch_port;
  logic        read_valid;
  logic [31:0] now_ms;
  logic [3:0]  ack_events;
  logic [3:0]  fail_events;
  logic [3:0]  send_accept;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  send_mask;
  logic [7:0]  led_port_a;
  logic [7:0]  led_port_b;
  logic        arm_led;
  logic [7:0]  channel_states;

  kill_switch_channel_controller_unit dut (.*);

  // predictor state
  logic [15:0] m_debounce;
  chan_state_t m_state [MAX_CHANNELS];
  logic [7:0]  m_fault_rx;
  logic [7:0]  m_killed;
  logic [3:0]  m_raw;
  logic [3:0]  m_stable;
  logic [31:0] m_since;

  poll_result_t pending_results [$];
  int          mismatch_count = 0;
  int          polls_sent = 0;
  int          results_seen = 0;
  int          kill_results = 0;
  int          debounce_writes = 0;
  int          cycle_count = 0;
  int          in_idle_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  int          step_limit = 8;
  logic [31:0] poll_clock = 32'd0;
  logic [3:0]  held_target = 4'h0;
  logic        arm_level = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (rst) stall_left = 0;
    else if (stall_left != 0) stall_left--;
    else if (stall_pct != 0 && $urandom_range(99) < stall_pct) stall_left = pick_gap();
    out_stall = (stall_left != 0);
  end

  function automatic void reset_model();
    m_debounce = DEBOUNCE_INIT;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) m_state[ch] = CH_IDLE;
    m_fault_rx = '0;
    m_killed = '0;
    m_raw = '0;
    m_stable = '0;
    m_since = '0;
  endfunction

  function automatic void launch_kill(input int ch, input logic accept,
                                      inout logic [3:0] sent);
    if (accept) begin
      m_state[ch] = CH_FLIGHT;
      sent[ch] = 1'b1;
    end else begin
      m_fault_rx[ch] = 1'b1;
      m_state[ch] = CH_IDLE;
    end
  endfunction

  function automatic poll_result_t predict_poll(input poll_word_t w);
    poll_result_t r;
    logic [3:0]   raw;
    logic [3:0]   sent;
    logic         held;
    sent = '0;
    if (w.read_valid) begin
      raw = ~w.switch_port[3:0] & SWITCH_MASK;
      if (raw != m_raw) begin
        m_raw = raw;
        m_since = w.now_ms;
      end else if (w.now_ms - m_since >= {16'd0, m_debounce}) begin
        m_stable = raw;
      end
    end
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      held = m_stable[ch];
      if (w.ack_events[ch]) begin
        m_fault_rx[4 + ch] = 1'b1;
        m_state[ch] = CH_DONE;
      end
      if (w.fail_events[ch]) begin
        m_fault_rx[ch] = 1'b1;
        if (held) launch_kill(ch, w.send_accept[ch], sent);
        else m_state[ch] = CH_IDLE;
      end
      if (w.armed) begin
        if (!held) begin
          m_state[ch] = CH_IDLE;
          m_fault_rx[ch] = 1'b0;
          m_fault_rx[4 + ch] = 1'b0;
          m_killed[4 + ch] = 1'b0;
        end else if (m_state[ch] == CH_IDLE) begin
          m_killed[4 + ch] = 1'b1;
          launch_kill(ch, w.send_accept[ch], sent);
        end
      end
    end
    r.send_mask = sent;
    r.led_port_a = m_fault_rx;
    r.led_port_b = m_killed & 8'hF0;
    r.arm_led = w.armed;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) r.channel_states[2 * ch +: 2] = m_state[ch];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got 0x%02h, expected 0x%02h", results_seen, field,
             got, want);
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin
    poll_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, send_mask", {4'h0, send_mask}, 8'h00);
      end else begin
        want = pending_results.pop_front();
        check_field("send_mask", {4'h0, send_mask}, {4'h0, want.send_mask});
        check_field("led_port_a", led_port_a, want.led_port_a);
        check_field("led_port_b", led_port_b, want.led_port_b);
        check_field("arm_led", {7'h00, arm_led}, {7'h00, want.arm_led});
        check_field("channel_states", channel_states, want.channel_states);
        if (want.send_mask != 4'h0) kill_results++;
      end
      results_seen++;
    end
  end

  task automatic drive_poll_word(input poll_word_t w);
    @(negedge clk);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    armed = w.armed;
    switch_port = w.switch_port;
    read_valid = w.read_valid;
    now_ms = w.now_ms;
    ack_events = w.ack_events;
    fail_events = w.fail_events;
    send_accept = w.send_accept;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_poll(w));
    polls_sent++;
  endtask

  // drain the block before touching the register
  task automatic set_debounce(input logic [15:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    m_debounce = value;
    debounce_writes++;
  endtask

  function automatic poll_word_t make_poll(input logic a, input logic [7:0] port,
                                           input logic rv, input logic [31:0] t,
                                           input logic [3:0] ack, input logic [3:0] fail,
                                           input logic [3:0] acc);
    poll_word_t w;
    w.armed = a;
    w.switch_port = port;
    w.read_valid = rv;
    w.now_ms = t;
    w.ack_events = ack;
    w.fail_events = fail;
    w.send_accept = acc;
    return w;
  endfunction

  function automatic logic [3:0] sparse_events();
    if ($urandom_range(99) < 25) return 4'($urandom_range(15)) & 4'($urandom_range(15));
    return 4'h0;
  endfunction

  function automatic poll_word_t next_random_poll();
    poll_word_t w;
    if ($urandom_range(99) < 10) begin
      w.armed = 1'($urandom_range(1));
      w.switch_port = 8'($urandom_range(255));
      w.read_valid = 1'($urandom_range(1));
      w.now_ms = $urandom();
      w.ack_events = 4'($urandom_range(15));
      w.fail_events = 4'($urandom_range(15));
      w.send_accept = 4'($urandom_range(15));
      return w;
    end
    if ($urandom_range(99) < 8) held_target = 4'($urandom_range(15));
    if ($urandom_range(99) < 5) arm_level = ~arm_level;
    if ($urandom_range(99) < 4) poll_clock += $urandom();
    else poll_clock += $urandom_range(0, step_limit);
    w.armed = arm_level;
    w.switch_port = {4'($urandom_range(15)), ~held_target};
    // contact bounce
    if ($urandom_range(99) < 4) w.switch_port[3:0] = 4'($urandom_range(15));
    w.read_valid = ($urandom_range(99) >= 8);
    w.now_ms = poll_clock;
    w.ack_events = sparse_events();
    w.fail_events = sparse_events();
    w.send_accept = $urandom_range(1) ? 4'hF : 4'($urandom_range(15));
    return w;
  endfunction

  task automatic run_random_polls(input int count, input logic [15:0] debounce,
                                  input int idle_pct, input int stall_level);
    set_debounce(debounce);
    step_limit = debounce / 4 + 2;
    in_idle_pct = idle_pct;
    stall_pct = stall_level;
    poll_clock = $urandom();
    arm_level = 1'b1;
    repeat (count) drive_poll_word(next_random_poll());
  endtask

  task automatic test_directed_cases();
    in_idle_pct = 20;
    stall_pct = 20;
    drive_poll_word(make_poll(1'b0, 8'hFF, 1'b1, 32'd1000, 4'h0, 4'h0, 4'h0));
    drive_poll_word(make_poll(1'b1, 8'h00, 1'b1, 32'd1001, 4'h0, 4'h0, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'h00, 1'b1, 32'd1025, 4'h0, 4'h0, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'h00, 1'b1, 32'd1026, 4'h0, 4'h0, 4'h5));
    drive_poll_word(make_poll(1'b1, 8'h00, 1'b1, 32'd1027, 4'h1, 4'h4, 4'hA));
    drive_poll_word(make_poll(1'b1, 8'h00, 1'b1, 32'd1028, 4'h2, 4'h2, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'hFF, 1'b0, 32'd1029, 4'h8, 4'h0, 4'hF));
    drive_poll_word(make_poll(1'b0, 8'hFF, 1'b1, 32'd1030, 4'h0, 4'h1, 4'hF));
    drive_poll_word(make_poll(1'b0, 8'hFF, 1'b1, 32'd1055, 4'h0, 4'h2, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'hFF, 1'b1, 32'd1056, 4'h0, 4'h0, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'hF0, 1'b1, 32'hFFFF_FFF0, 4'h0, 4'h0, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'hA0, 1'b1, 32'h0000_0009, 4'h0, 4'h0, 4'h0));
    drive_poll_word(make_poll(1'b1, 8'h50, 1'b1, 32'h0000_000A, 4'hF, 4'hF, 4'hF));
    drive_poll_word(make_poll(1'b1, 8'h5A, 1'b1, 32'hFFFF_FFFF, 4'h0, 4'hF, 4'h0));
    drive_poll_word(make_poll(1'b0, 8'h00, 1'b0, 32'h0000_0000, 4'h0, 4'h0, 4'h0));
    drive_poll_word(make_poll(1'b1, 8'hA5, 1'b1, 32'h8000_0000, 4'h5, 4'hA, 4'h3));
  endtask

  task automatic test_debounce_extremes();
    run_random_polls(110, 16'd0, 25, 25);
    run_random_polls(110, 16'hFFFF, 25, 25);
  endtask

  task automatic test_random_traffic();
    run_random_polls(110, 16'd1, 40, 40);
    run_random_polls(110, 16'($urandom_range(2, 300)), 15, 50);
  endtask

  task automatic test_back_to_back();
    run_random_polls(110, 16'($urandom()), 0, 0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    armed = 1'b0;
    switch_port = '0;
    read_valid = 1'b0;
    now_ms = '0;
    ack_events = '0;
    fail_events = '0;
    send_accept = '0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_debounce_extremes();
    test_random_traffic();
    test_back_to_back();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d polls over %0d debounce settings plus the reset value", polls_sent,
             debounce_writes);
    $display("checked %0d result words, %0d with kill sends, %0d mismatches", results_seen,
             kill_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### kill_switch_channel_controller_unit.f
rtl/kscc_pkg.sv
rtl/kscc_channel.sv
rtl/kill_switch_channel_controller_unit.sv
test/tb_kill_switch_channel_controller_unit.sv
